FILE: sv/hsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types, constants and sector role helpers for the HSV to RGB core.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int unsigned HueW   = 9;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SecW   = 3;
  localparam int unsigned OffW   = 6;
  localparam int unsigned MixW   = 13;  // 60*100 max
  localparam int unsigned VmW    = 20;  // 100*6000 max
  localparam int unsigned ProdW  = 28;  // 255*100*6000 max
  localparam int unsigned NumChan = 3;

  localparam logic [HueW-1:0] HueMax    = 9'd360;
  localparam logic [PctW-1:0] PctMax    = 7'd100;
  localparam logic [OffW-1:0] SectorDeg = 6'd60;
  localparam logic [ProdW-1:0] ScaleDiv = 28'd600000;

  // floor(x/600000) ~ (x*RecipMul) >> RecipShift, low by at most one
  localparam int unsigned RecipShift = 40;
  localparam int unsigned RecipW     = 21;
  localparam int unsigned RecipProdW = ProdW + RecipW;
  localparam logic [RecipW-1:0] RecipMul =
      RecipW'((64'd1 << RecipShift) / 64'd600000);

  typedef enum logic [1:0] {
    ROLE_OFF,
    ROLE_FULL,
    ROLE_RISE,
    ROLE_FALL
  } role_e;

  typedef struct packed {
    logic [HueW-1:0] hue_deg;
    logic [PctW-1:0] saturation_pct;
    logic [PctW-1:0] value_pct;
  } hsv_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } hsv_out_t;

  typedef struct packed {
    logic [SecW-1:0] sector;
    logic [OffW-1:0] offset;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
  } sector_t;

  typedef logic [NumChan-1:0][ProdW-1:0] prod_t;

  // channel 0 red, 1 green, 2 blue
  function automatic role_e sector_role(logic [SecW-1:0] sector, logic [1:0] ch);
    role_e r;
    role_e g;
    role_e b;
    case (sector)
      3'd0: begin r = ROLE_FULL; g = ROLE_RISE; b = ROLE_OFF;  end
      3'd1: begin r = ROLE_FALL; g = ROLE_FULL; b = ROLE_OFF;  end
      3'd2: begin r = ROLE_OFF;  g = ROLE_FULL; b = ROLE_RISE; end
      3'd3: begin r = ROLE_OFF;  g = ROLE_FALL; b = ROLE_FULL; end
      3'd4: begin r = ROLE_RISE; g = ROLE_OFF;  b = ROLE_FULL; end
      default: begin r = ROLE_FULL; g = ROLE_OFF; b = ROLE_FALL; end
    endcase
    case (ch)
      2'd0:    return r;
      2'd1:    return g;
      default: return b;
    endcase
  endfunction

  function automatic logic [OffW-1:0] role_weight(role_e role, logic [OffW-1:0] offset);
    case (role)
      ROLE_FULL: return SectorDeg;
      ROLE_RISE: return offset;
      ROLE_FALL: return SectorDeg - offset;
      default:   return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: sv/hsv_to_rgb_converter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// HSV (degrees, percent, percent) to 8-bit RGB pixel converter.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pixel_i and raise start_i for one cycle per pixel; a beat is taken
//   at every rising edge where start_i is high and busy_o is low. busy_o is
//   always low: the pipeline takes one pixel every cycle.
//   Each result appears on rgb_o for exactly one cycle with done_o high,
//   after six register stages (clamp/sector, mix, scale, reciprocal
//   estimate, back-multiply, correction). Results leave in input order.
//   Throughput is one pixel per clock, set by the six-stage pipeline with
//   all three channels computed in parallel lanes.
//   Percentages above 100 saturate to 100; hue of 360 or above wraps to 0.
//   Reset clears all pipeline valid bits; in-flight pixels are dropped.
//   The receiver must take every result; there is no back pressure.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core import hsv_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire hsv_in_t pixel_i,
  output logic         busy_o,
  output logic         done_o,
  output hsv_out_t     rgb_o
);

  logic    sec_valid;
  sector_t sec;
  logic    prod_valid;
  prod_t   prod;

  assign busy_o = 1'b0;

  hsv_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .pix_i   (pixel_i),
    .valid_o (sec_valid),
    .sec_o   (sec)
  );

  hsv_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sec_valid),
    .sec_i   (sec),
    .valid_o (prod_valid),
    .prod_o  (prod)
  );

  hsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .prod_i  (prod),
    .valid_o (done_o),
    .rgb_o   (rgb_o)
  );

endmodule
`default_nettype wire

FILE: sv/hsv_sector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_sector
// Input clamp and hue split into sector and offset within the sector.
// ----------------------------------------------------------------------------
module hsv_sector import hsv_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  wire hsv_in_t pix_i,
  output logic         valid_o,
  output sector_t      sec_o
);

  logic            valid_q;
  sector_t         sec_q, sec_d;
  logic [HueW-1:0] hue;
  logic [HueW-1:0] base;
  logic [SecW-1:0] sector;

  always_comb begin
    // 360 and above wrap to sector 0, offset 0
    hue = (pix_i.hue_deg >= HueMax) ? '0 : pix_i.hue_deg;
    if (hue >= 9'd300) begin
      sector = 3'd5; base = 9'd300;
    end else if (hue >= 9'd240) begin
      sector = 3'd4; base = 9'd240;
    end else if (hue >= 9'd180) begin
      sector = 3'd3; base = 9'd180;
    end else if (hue >= 9'd120) begin
      sector = 3'd2; base = 9'd120;
    end else if (hue >= 9'd60) begin
      sector = 3'd1; base = 9'd60;
    end else begin
      sector = 3'd0; base = 9'd0;
    end
    sec_d.sector = sector;
    sec_d.offset = OffW'(hue - base);
    sec_d.sat    = (pix_i.saturation_pct > PctMax) ? PctMax : pix_i.saturation_pct;
    sec_d.val    = (pix_i.value_pct > PctMax) ? PctMax : pix_i.value_pct;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q <= sec_d;
  end

  assign valid_o = valid_q;
  assign sec_o   = sec_q;

endmodule
`default_nettype wire

FILE: sv/hsv_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_mix
// Per-channel weight and mix term, then scaling by 255 * value.
// ----------------------------------------------------------------------------
module hsv_mix import hsv_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  wire sector_t sec_i,
  output logic         valid_o,
  output prod_t        prod_o
);

  logic                           mix_valid_q;
  logic [NumChan-1:0][MixW-1:0]   mix_q, mix_d;
  logic [PctW-1:0]                val_q;
  logic                           prod_valid_q;
  prod_t                          prod_q, prod_d;
  logic [PctW-1:0]                inv_sat;
  logic [MixW-1:0]                base_mix;
  logic [OffW-1:0]                weight;
  logic [VmW-1:0]                 vm;

  // stage A: mix = 60*(100-sat) + sat*w
  always_comb begin
    inv_sat  = PctMax - sec_i.sat;
    base_mix = MixW'(inv_sat) * MixW'(SectorDeg);
    for (int ch = 0; ch < NumChan; ch++) begin
      weight     = role_weight(sector_role(sec_i.sector, 2'(ch)), sec_i.offset);
      mix_d[ch]  = base_mix + MixW'(sec_i.sat) * MixW'(weight);
    end
  end

  // stage B: prod = 255 * val * mix, the 255 as shift and subtract
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      vm         = VmW'(val_q) * VmW'(mix_q[ch]);
      prod_d[ch] = {vm, 8'd0} - ProdW'(vm);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_valid_q  <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      mix_valid_q  <= valid_i;
      prod_valid_q <= mix_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mix_q  <= mix_d;
    val_q  <= sec_i.val;
    prod_q <= prod_d;
  end

  assign valid_o = prod_valid_q;
  assign prod_o  = prod_q;

endmodule
`default_nettype wire

FILE: sv/hsv_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_div
// Division by 600000 per channel: reciprocal estimate, back-multiply,
// one-step correction. Three register stages.
// ----------------------------------------------------------------------------
module hsv_div import hsv_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  wire prod_t   prod_i,
  output logic         valid_o,
  output hsv_out_t     rgb_o
);

  logic [2:0]                      valid_q;
  logic [NumChan-1:0][ChanW-1:0]   est_q, est_d;
  prod_t                           prod_a_q;
  logic [NumChan-1:0][ChanW-1:0]   est_b_q;
  prod_t                           prod_b_q;
  prod_t                           back_q, back_d;
  logic [NumChan-1:0][ChanW-1:0]   quo;
  hsv_out_t                        rgb_q, rgb_d;
  logic [RecipProdW-1:0]           recip_prod;
  logic [ProdW-1:0]                rem;

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      recip_prod = RecipProdW'(prod_i[ch]) * RecipProdW'(RecipMul);
      est_d[ch]  = recip_prod[RecipShift +: ChanW];
    end
  end

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      back_d[ch] = ProdW'(est_q[ch]) * ScaleDiv;
    end
  end

  // estimate is exact or one low
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      rem     = prod_b_q[ch] - back_q[ch];
      quo[ch] = (rem >= ScaleDiv) ? est_b_q[ch] + 8'd1 : est_b_q[ch];
    end
    rgb_d.red   = quo[0];
    rgb_d.green = quo[1];
    rgb_d.blue  = quo[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    est_q    <= est_d;
    prod_a_q <= prod_i;
    est_b_q  <= est_q;
    prod_b_q <= prod_a_q;
    back_q   <= back_d;
    rgb_q    <= rgb_d;
  end

  assign valid_o = valid_q[2];
  assign rgb_o   = rgb_q;

endmodule
`default_nettype wire
